// ===== rtl/core/cassette_edge_interrupt_controller_top_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef CASSETTE_EDGE_INTERRUPT_CONTROLLER_TOP_MACROS_SVH
`define CASSETTE_EDGE_INTERRUPT_CONTROLLER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define CEIC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("ceic assertion failed");

// Next-cycle implication, disabled while reset is active.
`define CEIC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ceic assertion failed");

`endif

// ===== rtl/core/ceic_pkg.sv =====
package ceic_pkg;

	typedef enum logic [2:0] {
		ACT_PORT_WR = 3'd0,
		ACT_PORT_RD = 3'd1,
		ACT_SAMPLE  = 3'd2,
		ACT_TICK    = 3'd3,
		ACT_DISK    = 3'd4
	} action_t;

	typedef enum logic [1:0] {
		PORT_IRQ      = 2'd0,
		PORT_NMI      = 2'd1,
		PORT_SETTINGS = 2'd2,
		PORT_CASS     = 2'd3
	} port_t;

	// config register indexes
	localparam logic CFG_MODEL     = 1'b0;
	localparam logic CFG_THRESHOLD = 1'b1;

	localparam logic               MODEL_RESET     = 1'b1;
	localparam logic signed [15:0] THRESHOLD_RESET = -16'sd1638; // about -0.2 in Q2.13
	localparam logic [7:0]         NMI_STATUS_RESET = 8'hff;

	localparam logic [7:0] MASK_CASS_RISE = 8'h01;
	localparam logic [7:0] MASK_CASS_FALL = 8'h02;
	localparam logic [7:0] MASK_LATE_RTC  = 8'h04;
	localparam logic [7:0] MASK_EARLY_FDC = 8'h40;
	localparam logic [7:0] MASK_EARLY_RTC = 8'h80;
	localparam logic [7:0] MASK_NMI_FDC   = 8'h80;
	localparam logic [7:0] CASS_IRQ_KEEP  = 8'hfc;
	localparam logic [6:0] SETTINGS_KEEP  = 7'h7e;
	localparam logic [7:0] TAPE_SLOW_BIT  = 8'h80;

	typedef struct packed {
		logic [2:0]         action;
		logic [1:0]         port_select;
		logic [7:0]         write_data;
		logic signed [15:0] tape_sample;
		logic               disk_line;
	} item_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic       int_line;
		logic       nmi_pulse;
	} result_t;

	typedef struct packed {
		logic        we;
		logic        index;
		logic [15:0] data;
	} cfg_wr_t;

endpackage

// ===== rtl/core/ceic_ifs.sv =====
interface ceic_in_if;
	logic               valid;
	logic               ready;
	logic [2:0]         action;
	logic [1:0]         port_select;
	logic [7:0]         write_data;
	logic signed [15:0] tape_sample;
	logic               disk_line;

	modport source (output valid, output action, output port_select, output write_data,
		output tape_sample, output disk_line, input ready);
	modport sink (input valid, input action, input port_select, input write_data,
		input tape_sample, input disk_line, output ready);
endinterface

interface ceic_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] read_data;
	logic       int_line;
	logic       nmi_pulse;

	modport source (output valid, output read_data, output int_line, output nmi_pulse,
		input ready);
	modport sink (input valid, input read_data, input int_line, input nmi_pulse,
		output ready);
endinterface

// ===== rtl/core/ceic_core.sv =====
// Controller state and its one-pass update for a registered item.
module ceic_core (
	input  logic              clk,
	input  logic              arst_n,
	input  ceic_pkg::cfg_wr_t cfg,
	input  logic              advance,
	input  ceic_pkg::item_t   item_s1,
	output ceic_pkg::result_t result
);

	logic               model_q;
	logic signed [15:0] thr_q;
	logic [7:0]         irq_latch_q, irq_enable_q, nmi_enable_q, nmi_status_q, tape_bits_q;
	logic [6:0]         settings_q;
	logic               mode_q;
	logic signed [15:0] prev_q;
	logic               held_q;

	logic [7:0]         irq_latch_d, irq_enable_d, nmi_enable_d, nmi_status_d, tape_bits_d;
	logic [6:0]         settings_d;
	logic               mode_d;
	logic signed [15:0] prev_d;
	logic               held_d;
	logic [7:0]         rd;
	logic               pulse;
	logic               late;
	logic               fall, rise;

	assign late = model_q;
	assign fall = (prev_q > thr_q) && (item_s1.tape_sample < thr_q);
	assign rise = (prev_q < thr_q) && (item_s1.tape_sample > thr_q);

	always_comb begin
		irq_latch_d  = irq_latch_q;
		irq_enable_d = irq_enable_q;
		nmi_enable_d = nmi_enable_q;
		nmi_status_d = nmi_status_q;
		tape_bits_d  = tape_bits_q;
		settings_d   = settings_q;
		mode_d       = mode_q;
		prev_d       = prev_q;
		held_d       = held_q;
		rd           = 8'h00;
		pulse        = 1'b0;
		case (ceic_pkg::action_t'(item_s1.action))
			ceic_pkg::ACT_PORT_WR: begin
				case (ceic_pkg::port_t'(item_s1.port_select))
					ceic_pkg::PORT_IRQ: irq_enable_d = item_s1.write_data;
					ceic_pkg::PORT_NMI: nmi_enable_d = item_s1.write_data;
					ceic_pkg::PORT_SETTINGS: begin
						settings_d = item_s1.write_data[6:0] & ceic_pkg::SETTINGS_KEEP;
						mode_d     = item_s1.write_data[2];
					end
					default: begin
						tape_bits_d = tape_bits_q & ~ceic_pkg::TAPE_SLOW_BIT;
						if (!late) begin
							mode_d = item_s1.write_data[3];
						end
					end
				endcase
			end
			ceic_pkg::ACT_PORT_RD: begin
				case (ceic_pkg::port_t'(item_s1.port_select))
					ceic_pkg::PORT_IRQ: begin
						if (late) begin
							rd = ~(irq_enable_q & irq_latch_q);
						end else begin
							rd          = irq_latch_q;
							irq_latch_d = 8'h00;
						end
						held_d = 1'b0;
					end
					ceic_pkg::PORT_NMI: rd = ~(nmi_enable_q & nmi_status_q);
					ceic_pkg::PORT_SETTINGS: begin
						if (late) begin
							irq_latch_d = irq_latch_q & ~ceic_pkg::MASK_LATE_RTC;
						end
					end
					default: begin
						if (late) begin
							irq_latch_d = irq_latch_q & ceic_pkg::CASS_IRQ_KEEP;
							rd          = {1'b0, settings_q} | tape_bits_q;
						end else begin
							rd = {2'b00, ~mode_q, 5'b00000} | tape_bits_q;
						end
					end
				endcase
			end
			ceic_pkg::ACT_SAMPLE: begin
				if (fall) begin
					tape_bits_d = tape_bits_q | ceic_pkg::TAPE_SLOW_BIT;
					if ((irq_enable_q & ceic_pkg::MASK_CASS_FALL) != 8'h00) begin
						tape_bits_d = 8'h00;
						irq_latch_d = irq_latch_q | ceic_pkg::MASK_CASS_FALL;
						held_d      = 1'b1;
					end
				end else if (rise) begin
					if ((irq_enable_q & ceic_pkg::MASK_CASS_RISE) != 8'h00) begin
						tape_bits_d = 8'h01;
						irq_latch_d = irq_latch_q | ceic_pkg::MASK_CASS_RISE;
						held_d      = 1'b1;
					end
				end
				prev_d = item_s1.tape_sample;
			end
			ceic_pkg::ACT_TICK: begin
				if (late) begin
					if ((irq_enable_q & ceic_pkg::MASK_LATE_RTC) != 8'h00) begin
						irq_latch_d = irq_latch_q | ceic_pkg::MASK_LATE_RTC;
						held_d      = 1'b1;
					end
				end else begin
					irq_latch_d = irq_latch_q | ceic_pkg::MASK_EARLY_RTC;
					held_d      = 1'b1;
				end
			end
			ceic_pkg::ACT_DISK: begin
				if (item_s1.disk_line) begin
					if (late) begin
						if ((nmi_enable_q & ceic_pkg::MASK_NMI_FDC) != 8'h00) begin
							nmi_status_d = ceic_pkg::MASK_NMI_FDC;
							pulse        = 1'b1;
						end
					end else begin
						irq_latch_d = irq_latch_q | ceic_pkg::MASK_EARLY_FDC;
						held_d      = 1'b1;
					end
				end else begin
					if (late) begin
						nmi_status_d = 8'h00;
					end else begin
						irq_latch_d = irq_latch_q & ~ceic_pkg::MASK_EARLY_FDC;
					end
				end
			end
			default: ;
		endcase
	end

	assign result.read_data = rd;
	assign result.int_line  = held_d;
	assign result.nmi_pulse = pulse;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			model_q      <= ceic_pkg::MODEL_RESET;
			thr_q        <= ceic_pkg::THRESHOLD_RESET;
			irq_latch_q  <= 8'h00;
			irq_enable_q <= 8'h00;
			nmi_enable_q <= 8'h00;
			nmi_status_q <= ceic_pkg::NMI_STATUS_RESET;
			tape_bits_q  <= 8'h00;
			settings_q   <= 7'h00;
			mode_q       <= 1'b0;
			prev_q       <= 16'sd0;
			held_q       <= 1'b0;
		end else begin
			if (cfg.we) begin
				if (cfg.index == ceic_pkg::CFG_MODEL) begin
					model_q <= cfg.data[0];
				end else begin
					thr_q <= cfg.data;
				end
			end
			if (advance) begin
				irq_latch_q  <= irq_latch_d;
				irq_enable_q <= irq_enable_d;
				nmi_enable_q <= nmi_enable_d;
				nmi_status_q <= nmi_status_d;
				tape_bits_q  <= tape_bits_d;
				settings_q   <= settings_d;
				mode_q       <= mode_d;
				prev_q       <= prev_d;
				held_q       <= held_d;
			end
		end
	end

endmodule

// ===== rtl/core/cassette_edge_interrupt_controller_top.sv =====
// Cassette-edge and interrupt controller. Each transaction on the item channel
// (port write, port read, cassette sample, clock tick or disk line change) yields
// exactly one transaction on the result channel carrying the read byte, the
// maskable interrupt line and the NMI pulse. An accepted item passes through the
// item register and then the result register; one item is taken every cycle as
// long as the result channel keeps draining, since the only work is a single pass
// of masks and signed threshold compares between the item register and the result
// register. Configuration (model rules, crossing threshold) is written through
// cfg_we/cfg_index/cfg_data and must only be changed while the block is idle.
module cassette_edge_interrupt_controller_top (
	input  logic        clk,
	input  logic        arst_n,
	ceic_in_if.sink     item,
	ceic_out_if.source  result,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data
);

	// item register (stage 1)
	ceic_pkg::item_t   item_s1;
	logic              valid_s1;
	// result register
	ceic_pkg::result_t result_q;
	logic              result_valid_q;

	ceic_pkg::result_t result_d;
	ceic_pkg::cfg_wr_t cfg;
	logic              advance;
	logic              take;

	// Stage 1 moves into the result register whenever that register is empty
	// or being drained this cycle.
	assign advance    = valid_s1 && (!result_valid_q || result.ready);
	assign item.ready = !valid_s1 || advance;
	assign take       = item.valid && item.ready;

	assign cfg.we    = cfg_we;
	assign cfg.index = cfg_index;
	assign cfg.data  = cfg_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1.action      <= item.action;
			item_s1.port_select <= item.port_select;
			item_s1.write_data  <= item.write_data;
			item_s1.tape_sample <= item.tape_sample;
			item_s1.disk_line   <= item.disk_line;
		end
	end

	// all controller state lives here; item-driven state commits only when the item advances, configuration on cfg_we
	ceic_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.advance (advance),
		.item_s1 (item_s1),
		.result  (result_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= 1'b1;
		end else if (result.ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= result_d;
		end
	end

	assign result.valid     = result_valid_q;
	assign result.read_data = result_q.read_data;
	assign result.int_line  = result_q.int_line;
	assign result.nmi_pulse = result_q.nmi_pulse;

endmodule

// ===== rtl/core/ceic_checker.sv =====
`include "cassette_edge_interrupt_controller_top_macros.svh"

module ceic_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       item_valid,
	input logic       item_ready,
	input logic       result_valid,
	input logic       result_ready,
	input logic [7:0] read_data,
	input logic       int_line,
	input logic       nmi_pulse
);

	// stalled result holds
	`CEIC_ASSERT_NEXT(a_result_hold, clk, arst_n, result_valid && !result_ready, result_valid && $stable(read_data) && $stable(int_line) && $stable(nmi_pulse))

	// an NMI pulse only comes from a disk event, never from a read
	`CEIC_ASSERT_NOW(a_nmi_no_data, clk, arst_n, result_valid && nmi_pulse, read_data == 8'h00)

	// empty output never backs up the input side
	`CEIC_ASSERT_NOW(a_ready_when_empty, clk, arst_n, !result_valid, item_ready)

	// an item taken while the output is idle reaches result valid via the item register and the result register
	`CEIC_ASSERT_NEXT(a_result_latency, clk, arst_n, item_valid && item_ready && !result_valid, ##1 result_valid)

endmodule

bind cassette_edge_interrupt_controller_top ceic_checker u_ceic_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item.valid),
	.item_ready   (item.ready),
	.result_valid (result.valid),
	.result_ready (result.ready),
	.read_data    (result.read_data),
	.int_line     (result.int_line),
	.nmi_pulse    (result.nmi_pulse)
);
